/* hdl/paap_pkg.sv */
// ----------------------------------------------------------------------------
// paap_pkg
// Shared constants, types and register codes of the pedal average block.
// ----------------------------------------------------------------------------
package paap_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned WINDOW      = 20;

  localparam int unsigned PCT_W  = 7;
  localparam int unsigned POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
  // (max - avg) * 100 + span / 2 is the widest dividend
  localparam int unsigned DIV_W  = SAMPLE_BITS + PCT_W;
  localparam int unsigned DEN_W  = SAMPLE_BITS;
  localparam int unsigned STEP_W = $clog2(DIV_W);

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  localparam logic [SAMPLE_BITS-1:0] BRAKE_MIN_RST = SAMPLE_BITS'(2250);
  localparam logic [SAMPLE_BITS-1:0] BRAKE_MAX_RST = SAMPLE_BITS'(3650);
  localparam logic [SAMPLE_BITS-1:0] GAS_MIN_RST   = SAMPLE_BITS'(440);
  localparam logic [SAMPLE_BITS-1:0] GAS_MAX_RST   = SAMPLE_BITS'(3650);
  localparam logic [PCT_W-1:0]       THRESH_RST    = PCT_W'(20);

  typedef enum logic [2:0] {
    REG_BRAKE_MIN = 3'd0,
    REG_BRAKE_MAX = 3'd1,
    REG_GAS_MIN   = 3'd2,
    REG_GAS_MAX   = 3'd3,
    REG_THRESH    = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_AVG_B_GO,
    S_AVG_B_WT,
    S_AVG_G_GO,
    S_AVG_G_WT,
    S_PCT_B_GO,
    S_PCT_B_WT,
    S_PCT_G_GO,
    S_PCT_G_WT,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] brake_min;
    logic [SAMPLE_BITS-1:0] brake_max;
    logic [SAMPLE_BITS-1:0] gas_min;
    logic [SAMPLE_BITS-1:0] gas_max;
    logic [PCT_W-1:0]       thresh;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_b;
    logic [SUM_W-1:0] sum_g;
    logic [CNT_W-1:0] count;
  } win_t;

endpackage

/* hdl/paap_cfg.sv */
// ----------------------------------------------------------------------------
// paap_cfg
// APB register file: clamp bounds and pressed threshold.
// ----------------------------------------------------------------------------
module paap_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [paap_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [paap_pkg::DATA_W-1:0]  pwdata_i,
  output logic [paap_pkg::DATA_W-1:0]  prdata_o,
  output logic                         pready_o,
  output paap_pkg::cfg_t               cfg_o
);
  import paap_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx      = reg_idx_e'(paddr_i[ADDR_W-1:2]);
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brake_min <= BRAKE_MIN_RST;
      cfg_q.brake_max <= BRAKE_MAX_RST;
      cfg_q.gas_min   <= GAS_MIN_RST;
      cfg_q.gas_max   <= GAS_MAX_RST;
      cfg_q.thresh    <= THRESH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_BRAKE_MIN: cfg_q.brake_min <= pwdata_i[SAMPLE_BITS-1:0];
        REG_BRAKE_MAX: cfg_q.brake_max <= pwdata_i[SAMPLE_BITS-1:0];
        REG_GAS_MIN:   cfg_q.gas_min   <= pwdata_i[SAMPLE_BITS-1:0];
        REG_GAS_MAX:   cfg_q.gas_max   <= pwdata_i[SAMPLE_BITS-1:0];
        REG_THRESH:    cfg_q.thresh    <= pwdata_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    case (idx)
      REG_BRAKE_MIN: prdata_o = DATA_W'(cfg_q.brake_min);
      REG_BRAKE_MAX: prdata_o = DATA_W'(cfg_q.brake_max);
      REG_GAS_MIN:   prdata_o = DATA_W'(cfg_q.gas_min);
      REG_GAS_MAX:   prdata_o = DATA_W'(cfg_q.gas_max);
      REG_THRESH:    prdata_o = DATA_W'(cfg_q.thresh);
      default:       prdata_o = '0;
    endcase
  end

endmodule

/* hdl/paap_window.sv */
// ----------------------------------------------------------------------------
// paap_window
// Brake and gas sample windows with running sums and fill tracking.
// ----------------------------------------------------------------------------
module paap_window (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [paap_pkg::SAMPLE_BITS-1:0] brake_i,
  input  logic [paap_pkg::SAMPLE_BITS-1:0] gas_i,
  output paap_pkg::win_t                   win_o
);
  import paap_pkg::*;

  logic [SAMPLE_BITS-1:0] win_b_q [WINDOW];
  logic [SAMPLE_BITS-1:0] win_g_q [WINDOW];
  logic [POS_W-1:0]       pos_q;
  logic                   full_q;
  logic [SUM_W-1:0]       sum_b_q, sum_g_q;
  logic [CNT_W-1:0]       count_q;
  logic [SAMPLE_BITS-1:0] old_b, old_g;
  logic                   wrap;

  // entries not yet written since reset read as zero
  assign old_b = full_q ? win_b_q[pos_q] : '0;
  assign old_g = full_q ? win_g_q[pos_q] : '0;
  assign wrap  = (pos_q == POS_W'(WINDOW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      full_q  <= 1'b0;
      sum_b_q <= '0;
      sum_g_q <= '0;
      count_q <= CNT_W'(1);
    end else if (push_i) begin
      sum_b_q <= sum_b_q - SUM_W'(old_b) + SUM_W'(brake_i);
      sum_g_q <= sum_g_q - SUM_W'(old_g) + SUM_W'(gas_i);
      count_q <= full_q ? CNT_W'(WINDOW) : CNT_W'(pos_q) + CNT_W'(1);
      if (wrap) begin
        pos_q  <= '0;
        full_q <= 1'b1;
      end else begin
        pos_q <= pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      win_b_q[pos_q] <= brake_i;
      win_g_q[pos_q] <= gas_i;
    end
  end

  assign win_o.sum_b = sum_b_q;
  assign win_o.sum_g = sum_g_q;
  assign win_o.count = count_q;

endmodule

/* hdl/paap_divider.sv */
// ----------------------------------------------------------------------------
// paap_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module paap_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [paap_pkg::DIV_W-1:0] dividend_i,
  input  logic [paap_pkg::DEN_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [paap_pkg::DIV_W-1:0] quotient_o
);
  import paap_pkg::*;

  logic [DIV_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q, den_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic              fits;

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DIV_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], fits};
      rem_q <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && !$past(start_i) |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

/* hdl/pedal_adc_average_percent.sv */
// ----------------------------------------------------------------------------
// pedal_adc_average_percent
// Clamped moving average of brake and gas samples, mapped to percent.
// ----------------------------------------------------------------------------
// Each transfer carries one brake and one gas sample. Samples are clamped to
// their register bounds, averaged over the last 20 samples (fewer until the
// window fills) and mapped to a rounded percent, 0 at the max bound and 100 at
// the min bound. All four divisions (two averages, two percents) run in turn
// through one shared bit-serial divider of 19 steps. A percent division is
// skipped, and its percent set to 0, for an empty span or an average at or
// above the max bound. in_stall_o stays high until the result is loaded, so
// the next input transfer is taken only after that, and later while the
// output register still holds an unsent result. A finished result waits in
// the output register while the next item is taken.
// Window stores need no clearing pass after reset.
module pedal_adc_average_percent (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [paap_pkg::SAMPLE_BITS-1:0] brake_raw_i,
  input  logic [paap_pkg::SAMPLE_BITS-1:0] gas_raw_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [paap_pkg::PCT_W-1:0]       brake_pct_o,
  output logic [paap_pkg::PCT_W-1:0]       gas_pct_o,
  output logic                             brake_pressed_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [paap_pkg::ADDR_W-1:0]      paddr,
  input  logic [paap_pkg::DATA_W-1:0]      pwdata,
  output logic [paap_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);
  import paap_pkg::*;

  cfg_t       cfg;
  win_t       win;
  seq_state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] b_smp_q, g_smp_q, b_avg_q, g_avg_q;
  logic [SAMPLE_BITS-1:0] b_lo, b_hi, g_lo, g_hi;
  logic [PCT_W-1:0]       b_pct_q, g_pct_q;
  logic [PCT_W-1:0]       out_b_q, out_g_q;
  logic                   out_p_q, out_valid_q;
  logic                   in_acc, push, load_out;

  logic                   div_start, div_busy, div_done;
  logic [DIV_W-1:0]       div_num, div_quo;
  logic [DEN_W-1:0]       div_den;
  logic [PCT_W-1:0]       quo_sat;

  logic                   pct_gas, pct_skip;
  logic [SAMPLE_BITS-1:0] p_lo, p_hi, p_avg, p_diff, p_span;
  logic [DIV_W-1:0]       p_num;

  paap_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  paap_window u_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .brake_i (b_smp_q),
    .gas_i   (g_smp_q),
    .win_o   (win)
  );

  paap_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign b_lo = cfg.brake_min;
  assign b_hi = cfg.brake_max;
  assign g_lo = cfg.gas_min;
  assign g_hi = cfg.gas_max;

  // percent operands, shared between the two channels
  assign pct_gas  = (state_q == S_PCT_G_GO);
  assign p_lo     = pct_gas ? g_lo : b_lo;
  assign p_hi     = pct_gas ? g_hi : b_hi;
  assign p_avg    = pct_gas ? g_avg_q : b_avg_q;
  assign pct_skip = (p_hi <= p_lo) || (p_avg >= p_hi);
  assign p_diff   = p_hi - p_avg;
  assign p_span   = p_hi - p_lo;
  assign p_num    = DIV_W'(p_diff) * DIV_W'(100) + DIV_W'(p_span >> 1);

  assign quo_sat = (div_quo > DIV_W'(PCT_MAX)) ? PCT_MAX : div_quo[PCT_W-1:0];

  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    push       = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    load_out   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = S_PUSH;
      end
      S_PUSH: begin
        push    = 1'b1;
        state_d = S_AVG_B_GO;
      end
      S_AVG_B_GO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(win.sum_b);
        div_den   = DEN_W'(win.count);
        state_d   = S_AVG_B_WT;
      end
      S_AVG_B_WT: begin
        if (div_done) state_d = S_AVG_G_GO;
      end
      S_AVG_G_GO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(win.sum_g);
        div_den   = DEN_W'(win.count);
        state_d   = S_AVG_G_WT;
      end
      S_AVG_G_WT: begin
        if (div_done) state_d = S_PCT_B_GO;
      end
      S_PCT_B_GO: begin
        if (pct_skip) begin
          state_d = S_PCT_G_GO;
        end else begin
          div_start = 1'b1;
          div_num   = p_num;
          div_den   = DEN_W'(p_span);
          state_d   = S_PCT_B_WT;
        end
      end
      S_PCT_B_WT: begin
        if (div_done) state_d = S_PCT_G_GO;
      end
      S_PCT_G_GO: begin
        if (pct_skip) begin
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = p_num;
          div_den   = DEN_W'(p_span);
          state_d   = S_PCT_G_WT;
        end
      end
      S_PCT_G_WT: begin
        if (div_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // clamp: lower bound first, then upper
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (brake_raw_i < b_lo)      b_smp_q <= (b_lo > b_hi) ? b_hi : b_lo;
      else if (brake_raw_i > b_hi) b_smp_q <= b_hi;
      else                         b_smp_q <= brake_raw_i;
      if (gas_raw_i < g_lo)        g_smp_q <= (g_lo > g_hi) ? g_hi : g_lo;
      else if (gas_raw_i > g_hi)   g_smp_q <= g_hi;
      else                         g_smp_q <= gas_raw_i;
    end
    if (state_q == S_AVG_B_WT && div_done) b_avg_q <= div_quo[SAMPLE_BITS-1:0];
    if (state_q == S_AVG_G_WT && div_done) g_avg_q <= div_quo[SAMPLE_BITS-1:0];
    if (state_q == S_PCT_B_GO && pct_skip) b_pct_q <= '0;
    if (state_q == S_PCT_B_WT && div_done) b_pct_q <= quo_sat;
    if (state_q == S_PCT_G_GO && pct_skip) g_pct_q <= '0;
    if (state_q == S_PCT_G_WT && div_done) g_pct_q <= quo_sat;
    if (load_out) begin
      out_b_q <= b_pct_q;
      out_g_q <= g_pct_q;
      out_p_q <= (b_pct_q > cfg.thresh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign brake_pct_o     = out_b_q;
  assign gas_pct_o       = out_g_q;
  assign brake_pressed_o = out_p_q;

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (brake_pct_o <= PCT_MAX) && (gas_pct_o <= PCT_MAX))
    else $error("percent out of range");

  a_pressed_thresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brake_pressed_o |-> brake_pct_o > cfg.thresh)
    else $error("pressed flag without percent above threshold");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> !$past(load_out))
    else $error("pending result overwritten");

  a_done_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_AVG_B_WT || state_q == S_AVG_G_WT ||
                  state_q == S_PCT_B_WT || state_q == S_PCT_G_WT))
    else $error("divider result outside a wait state");

  a_busy_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == S_AVG_B_WT || state_q == S_AVG_G_WT ||
                  state_q == S_PCT_B_WT || state_q == S_PCT_G_WT))
    else $error("divider busy outside a wait state");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pedal_adc_average_percent: a table of directed
// transfers and register writes, then random phases that mostly pick new bounds. Every
// accepted sample pair is run through a local clamp/average/percent model and
// each output transfer is compared against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import paap_pkg::*;

  localparam int unsigned REG_COUNT  = 5;
  localparam int unsigned N_DIRECTED = 42;
  localparam int unsigned N_PHASES   = 13;
  localparam int unsigned PHASE_LEN  = 150;
  localparam int unsigned CYCLE_MAX  = 4_000_000;

  typedef struct packed {
    logic [PCT_W-1:0] brake_pct;
    logic [PCT_W-1:0] gas_pct;
    logic             pressed;
  } pedal_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // ROW_ITEM: a = brake, b = gas; ROW_CFG: a = register index, b = value
  typedef struct packed {
    row_kind_e             kind;
    logic [11:0]           a;
    logic [11:0]           b;
    logic                  typed;
    pedal_result_t         want;
  } step_t;

  localparam pedal_result_t NONE = '0;

  localparam step_t DIRECTED [N_DIRECTED] = '{
    '{ROW_ITEM, 12'd0,    12'd0,    1'b1, '{7'd100, 7'd100, 1'b1}},
    '{ROW_ITEM, 12'd4095, 12'd4095, 1'b1, '{7'd50,  7'd50,  1'b1}},
    '{ROW_ITEM, 12'd2250, 12'd440,  1'b0, NONE},
    '{ROW_ITEM, 12'd3650, 12'd3650, 1'b0, NONE},
    '{ROW_ITEM, 12'd2950, 12'd2045, 1'b0, NONE},
    '{ROW_ITEM, 12'hAAA,  12'h555,  1'b0, NONE},
    '{ROW_ITEM, 12'h555,  12'hAAA,  1'b0, NONE},
    // threshold above 100: never pressed
    '{ROW_CFG,  12'(REG_THRESH),    12'd101,  1'b0, NONE},
    '{ROW_ITEM, 12'd0,    12'd0,    1'b0, NONE},
    '{ROW_ITEM, 12'd1000, 12'd1000, 1'b0, NONE},
    // brake min above max, gas span empty
    '{ROW_CFG,  12'(REG_BRAKE_MIN), 12'd4095, 1'b0, NONE},
    '{ROW_CFG,  12'(REG_BRAKE_MAX), 12'd0,    1'b0, NONE},
    '{ROW_CFG,  12'(REG_GAS_MIN),   12'd2000, 1'b0, NONE},
    '{ROW_CFG,  12'(REG_GAS_MAX),   12'd2000, 1'b0, NONE},
    '{ROW_ITEM, 12'd1234, 12'd3000, 1'b1, '{7'd0, 7'd0, 1'b0}},
    '{ROW_ITEM, 12'd4095, 12'd0,    1'b1, '{7'd0, 7'd0, 1'b0}},
    // writes past the register list must not land anywhere
    '{ROW_CFG,  12'(REG_COUNT),     12'd4095, 1'b0, NONE},
    '{ROW_CFG,  12'(REG_COUNT + 1), 12'd0,    1'b0, NONE},
    '{ROW_CFG,  12'(REG_COUNT + 2), 12'd4095, 1'b0, NONE},
    '{ROW_ITEM, 12'd100,  12'd200,  1'b1, '{7'd0, 7'd0, 1'b0}},
    // full-scale bounds, threshold zero
    '{ROW_CFG,  12'(REG_BRAKE_MIN), 12'd0,    1'b0, NONE},
    '{ROW_CFG,  12'(REG_BRAKE_MAX), 12'd4095, 1'b0, NONE},
    '{ROW_CFG,  12'(REG_GAS_MIN),   12'd0,    1'b0, NONE},
    '{ROW_CFG,  12'(REG_GAS_MAX),   12'd4095, 1'b0, NONE},
    '{ROW_CFG,  12'(REG_THRESH),    12'd0,    1'b0, NONE},
    '{ROW_ITEM, 12'd0,    12'd4095, 1'b0, NONE},
    '{ROW_ITEM, 12'd4095, 12'd0,    1'b0, NONE},
    '{ROW_ITEM, 12'd4095, 12'd4095, 1'b0, NONE},
    '{ROW_ITEM, 12'd4095, 12'd4095, 1'b0, NONE},
    '{ROW_ITEM, 12'd4095, 12'd4095, 1'b0, NONE},
    // lower max under a high window: average above max
    '{ROW_CFG,  12'(REG_BRAKE_MAX), 12'd1000, 1'b0, NONE},
    '{ROW_CFG,  12'(REG_GAS_MAX),   12'd1000, 1'b0, NONE},
    '{ROW_ITEM, 12'd4095, 12'd4095, 1'b0, NONE},
    '{ROW_ITEM, 12'd500,  12'd500,  1'b0, NONE},
    // raise min over a low window: average below min
    '{ROW_CFG,  12'(REG_BRAKE_MAX), 12'd4095, 1'b0, NONE},
    '{ROW_CFG,  12'(REG_GAS_MAX),   12'd4095, 1'b0, NONE},
    '{ROW_CFG,  12'(REG_BRAKE_MIN), 12'd3000, 1'b0, NONE},
    '{ROW_CFG,  12'(REG_GAS_MIN),   12'd3000, 1'b0, NONE},
    '{ROW_ITEM, 12'd0,    12'd0,    1'b0, NONE},
    '{ROW_ITEM, 12'd3500, 12'd3500, 1'b0, NONE},
    '{ROW_CFG,  12'(REG_THRESH),    12'd127,  1'b0, NONE},
    '{ROW_ITEM, 12'd4095, 12'd0,    1'b0, NONE}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [SAMPLE_BITS-1:0] brake_raw_i = '0;
  logic [SAMPLE_BITS-1:0] gas_raw_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [PCT_W-1:0]       brake_pct_o;
  logic [PCT_W-1:0]       gas_pct_o;
  logic                   brake_pressed_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  pedal_adc_average_percent u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .brake_raw_i    (brake_raw_i),
    .gas_raw_i      (gas_raw_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .brake_pct_o    (brake_pct_o),
    .gas_pct_o      (gas_pct_o),
    .brake_pressed_o(brake_pressed_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk_i = ~clk_i;

  // ---- filter model state ----
  cfg_t        cfg;
  int unsigned brake_hist [WINDOW];
  int unsigned gas_hist [WINDOW];
  int unsigned brake_sum;
  int unsigned gas_sum;
  int unsigned wr_pos;
  bit          hist_full;

  pedal_result_t percent_q [$];
  pedal_result_t got;
  int            mismatches = 0;
  int            cycles = 0;
  bit            no_idle = 1'b0;
  int            stall_burst = 0;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic int unsigned to_pct(int unsigned avg, int unsigned lo, int unsigned hi);
    int unsigned span;
    int unsigned p;
    if (hi <= lo || avg >= hi) return 0;
    span = hi - lo;
    p = ((hi - avg) * 100 + span / 2) / span;
    return (p > 100) ? 100 : p;
  endfunction

  function automatic pedal_result_t filter_sample(logic [11:0] b, logic [11:0] g);
    int unsigned   cnt;
    int unsigned   bc;
    int unsigned   gc;
    int unsigned   bp;
    pedal_result_t r;
    cnt = hist_full ? WINDOW : wr_pos + 1;
    bc = clamp_to(b, cfg.brake_min, cfg.brake_max);
    gc = clamp_to(g, cfg.gas_min, cfg.gas_max);
    brake_sum = brake_sum - brake_hist[wr_pos] + bc;
    gas_sum = gas_sum - gas_hist[wr_pos] + gc;
    brake_hist[wr_pos] = bc;
    gas_hist[wr_pos] = gc;
    wr_pos++;
    if (wr_pos >= WINDOW) begin
      wr_pos = 0;
      hist_full = 1'b1;
    end
    bp = to_pct(brake_sum / cnt, cfg.brake_min, cfg.brake_max);
    r.brake_pct = PCT_W'(bp);
    r.gas_pct = PCT_W'(to_pct(gas_sum / cnt, cfg.gas_min, cfg.gas_max));
    r.pressed = (bp > cfg.thresh);
    return r;
  endfunction

  // mostly inside the clamp window, some full-scale noise and rail values
  function automatic logic [11:0] pick_sample(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return $urandom_range(1) ? 12'hFFF : 12'h000;
    if (r < 70 && lo < hi) return 12'($urandom_range(hi, lo));
    return 12'($urandom_range(4095));
  endfunction

  task automatic pick_bounds(output int unsigned lo, output int unsigned hi);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) begin
      lo = 0;
      hi = 4095;
    end else if (r == 1) begin
      hi = $urandom_range(4094);
      lo = $urandom_range(4095, hi + 1);
    end else if (r == 2) begin
      lo = $urandom_range(4095);
      hi = lo;
    end else begin
      lo = $urandom_range(4000);
      hi = $urandom_range(4095, lo + 1);
    end
  endtask

  task automatic write_reg(int unsigned idx, logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_BRAKE_MIN: cfg.brake_min = val[SAMPLE_BITS-1:0];
      REG_BRAKE_MAX: cfg.brake_max = val[SAMPLE_BITS-1:0];
      REG_GAS_MIN:   cfg.gas_min = val[SAMPLE_BITS-1:0];
      REG_GAS_MAX:   cfg.gas_max = val[SAMPLE_BITS-1:0];
      REG_THRESH:    cfg.thresh = val[PCT_W-1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // one input transfer; the typed result, if given, replaces the prediction
  task automatic send_pair(logic [11:0] b, logic [11:0] g, bit typed, pedal_result_t want);
    pedal_result_t r;
    if (!no_idle && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(150, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    brake_raw_i <= b;
    gas_raw_i <= g;
    do @(posedge clk_i); while (in_stall_o);
    r = filter_sample(b, g);
    percent_q.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (percent_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls plus rare long holds
  always @(posedge clk_i) begin
    int unsigned r;
    r = $urandom_range(999);
    if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
      out_stall_i <= 1'b1;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (r < 150);
      if (r == 150) stall_burst <= $urandom_range(150, 20);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (percent_q.size() == 0) begin
        $error("result transfer with nothing pending");
        mismatches++;
      end else begin
        got = percent_q.pop_front();
        if (brake_pct_o !== got.brake_pct) begin
          $error("brake_pct: expected %0d, got %0d", got.brake_pct, brake_pct_o);
          mismatches++;
        end
        if (gas_pct_o !== got.gas_pct) begin
          $error("gas_pct: expected %0d, got %0d", got.gas_pct, gas_pct_o);
          mismatches++;
        end
        if (brake_pressed_o !== got.pressed) begin
          $error("brake_pressed: expected %0d, got %0d", got.pressed, brake_pressed_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_MAX) begin
      $display("** pedal_adc_average_percent: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned lo;
    int unsigned hi;
    cfg = '{BRAKE_MIN_RST, BRAKE_MAX_RST, GAS_MIN_RST, GAS_MAX_RST, THRESH_RST};
    foreach (brake_hist[i]) begin
      brake_hist[i] = 0;
      gas_hist[i] = 0;
    end
    brake_sum = 0;
    gas_sum = 0;
    wr_pos = 0;
    hist_full = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        drain();
        write_reg(DIRECTED[i].a, DATA_W'(DIRECTED[i].b));
      end else begin
        send_pair(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain();
      no_idle = (phase == 4);
      // skipping some writes keeps the old window against new bounds
      if ($urandom_range(9) < 8) begin
        pick_bounds(lo, hi);
        write_reg(REG_BRAKE_MIN, DATA_W'(lo));
        write_reg(REG_BRAKE_MAX, DATA_W'(hi));
      end
      if ($urandom_range(9) < 8) begin
        pick_bounds(lo, hi);
        write_reg(REG_GAS_MIN, DATA_W'(lo));
        write_reg(REG_GAS_MAX, DATA_W'(hi));
      end
      if ($urandom_range(9) < 8)
        write_reg(REG_THRESH, ($urandom_range(9) < 8) ? $urandom_range(100)
                                                      : $urandom_range(127, 101));
      if ($urandom_range(3) == 0)
        write_reg(REG_COUNT + $urandom_range(2), $urandom_range(4095));
      for (int n = 0; n < PHASE_LEN; n++)
        send_pair(pick_sample(cfg.brake_min, cfg.brake_max),
                  pick_sample(cfg.gas_min, cfg.gas_max), 1'b0, NONE);
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && percent_q.size() == 0) begin
      $display("** pedal_adc_average_percent: PASSED **");
    end else begin
      $display("** pedal_adc_average_percent: FAILED **");
    end
    $finish;
  end

endmodule

/* pedal_adc_average_percent.f */
hdl/paap_pkg.sv
hdl/paap_cfg.sv
hdl/paap_window.sv
hdl/paap_divider.sv
hdl/pedal_adc_average_percent.sv
tb/tb.sv
